// ===== hw/rtl/cma_pkg.sv =====
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types and fixed constants of the centered moving average filter.
// ----------------------------------------------------------------------------
package cma_pkg;

  localparam int CFG_W     = 7;
  localparam int FRAC_BITS = 8;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd5;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    SRC_MEM,
    SRC_NEWEST,
    SRC_FIRST,
    SRC_ZERO
  } elem_src_t;

endpackage

// ===== hw/rtl/cma_in_if.sv =====
// ----------------------------------------------------------------------------
// cma_in_if
// Sample request channel: valid/ready with sample and end-of-set flag.
// ----------------------------------------------------------------------------
interface cma_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// ===== hw/rtl/cma_out_if.sv =====
// ----------------------------------------------------------------------------
// cma_out_if
// Average request channel: valid/ready with Q.8 average and end-of-set flag.
// ----------------------------------------------------------------------------
interface cma_out_if
  import cma_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
);
  logic                                    valid;
  logic                                    ready;
  logic signed [SAMPLE_BITS+FRAC_BITS-1:0] average;
  logic                                    last_average;

  modport source (output valid, output average, output last_average, input ready);
  modport sink   (input valid, input average, input last_average, output ready);
endinterface

// ===== hw/rtl/centered_moving_average.sv =====
// ----------------------------------------------------------------------------
// centered_moving_average
// Centered boxcar average with edge replication over signed sample sets.
// ----------------------------------------------------------------------------
// Each average takes W reads of the sample memory through its one read port, then
// a radix-2 divider of NUM_W steps. A sample that ends the set flushes up to
// W/2 + 1 averages back to back. Sample requests are taken only while no average
// is being computed. Reset is synchronous; the sample memory is not cleared and
// needs no sweep.
// ----------------------------------------------------------------------------
module centered_moving_average
  import cma_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             window_size_we,
  input  logic [CFG_W-1:0] window_size_wdata,
  cma_in_if.sink           samples,
  cma_out_if.source        averages
);

  localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
  localparam int RING_W     = $clog2(MAX_WINDOW);
  localparam int RING_DEPTH = 1 << RING_W;
  localparam int SUM_W      = SAMPLE_BITS + RING_W;
  localparam int NUM_W      = SUM_W + FRAC_BITS;
  localparam int AVG_W      = SAMPLE_BITS + FRAC_BITS;
  localparam int P_W        = WIN_W + 1;
  localparam int DCNT_W     = $clog2(NUM_W + 1);

  state_t state;

  logic [CFG_W-1:0]              window_size;
  logic                          set_active;
  logic [WIN_W-1:0]              seen;
  logic [WIN_W-1:0]              win_cur;
  logic [RING_W-1:0]             newest_ptr;
  logic signed [SAMPLE_BITS-1:0] newest;
  logic signed [SAMPLE_BITS-1:0] first;
  logic                          flushing;
  logic [WIN_W-1:0]              lag;

  logic signed [SAMPLE_BITS-1:0] ring [RING_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data;

  logic signed [P_W-1:0]         p;
  logic [WIN_W-1:0]              issue_cnt;
  logic                          pend;
  elem_src_t                     pend_src;
  logic signed [SUM_W-1:0]       acc;

  logic                          neg;
  logic [NUM_W-1:0]              quo;
  logic [WIN_W-1:0]              rem;
  logic [DCNT_W-1:0]             div_cnt;

  logic                          avg_valid;
  logic signed [AVG_W-1:0]       avg_data;
  logic                          avg_last;

  logic                          accept;
  logic [WIN_W-1:0]              win_cfg;
  logic [WIN_W-1:0]              win_eff;
  logic [WIN_W-1:0]              seen_base;
  logic [WIN_W-1:0]              seen_next;
  logic [WIN_W-1:0]              d_eff;
  logic [WIN_W-1:0]              off_eff;
  logic [WIN_W-1:0]              lag_first;
  logic                          emit;
  logic [WIN_W-1:0]              off_cur;
  logic [WIN_W-1:0]              lag_dec;
  logic signed [P_W-1:0]         neg_p;
  elem_src_t                     src;
  logic signed [SUM_W-1:0]       elem;
  logic signed [SUM_W-1:0]       acc_next;
  logic [NUM_W-1:0]              mag;
  logic [WIN_W:0]                trial;
  logic                          qbit;
  logic [NUM_W-1:0]              res;
  logic                          out_free;

  assign accept   = samples.valid && samples.ready;
  assign out_free = !avg_valid || averages.ready;

  always_comb begin
    if (window_size == '0) begin
      win_cfg = WIN_W'(1);
    end else if (int'(window_size) > MAX_WINDOW) begin
      win_cfg = WIN_W'(MAX_WINDOW);
    end else begin
      win_cfg = WIN_W'(window_size);
    end
    win_eff   = set_active ? win_cur : win_cfg;
    seen_base = set_active ? seen : '0;
    seen_next = (int'(seen_base) == MAX_WINDOW) ? seen_base : seen_base + WIN_W'(1);
    d_eff     = win_eff >> 1;
    off_eff   = (win_eff - WIN_W'(1)) >> 1;
    lag_first = d_eff;
    if (samples.last_sample && (seen_next - WIN_W'(1) < d_eff)) begin
      lag_first = seen_next - WIN_W'(1);
    end
    emit    = samples.last_sample || (seen_next > d_eff);
    off_cur = (win_cur - WIN_W'(1)) >> 1;
    lag_dec = lag - WIN_W'(1);
  end

  always_comb begin
    neg_p = -p;
    if (p < 0) begin
      src = (neg_p <= $signed({1'b0, off_cur})) ? SRC_NEWEST : SRC_ZERO;
    end else if (p >= $signed({1'b0, seen})) begin
      src = SRC_FIRST;
    end else begin
      src = SRC_MEM;
    end
  end

  always_comb begin
    unique case (pend_src)
      SRC_MEM:    elem = SUM_W'(rd_data);
      SRC_NEWEST: elem = SUM_W'(newest);
      SRC_FIRST:  elem = SUM_W'(first);
      SRC_ZERO:   elem = '0;
      default:    elem = '0;
    endcase
    acc_next = acc + elem;
    mag      = acc[SUM_W-1] ? NUM_W'(-{acc, {FRAC_BITS{1'b0}}})
                            : NUM_W'({acc, {FRAC_BITS{1'b0}}});
    trial    = {rem, quo[NUM_W-1]};
    qbit     = trial >= {1'b0, win_cur};
    res      = neg ? (-quo - NUM_W'(rem != '0)) : quo;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ring[newest_ptr + RING_W'(1)] <= samples.sample;
    end
    if (state == S_SUM && issue_cnt != '0) begin
      rd_data <= ring[newest_ptr - p[RING_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      window_size <= WINDOW_RESET;
      set_active  <= 1'b0;
      seen        <= '0;
      avg_valid   <= 1'b0;
      newest_ptr  <= '0;
    end else begin
      if (window_size_we) begin
        window_size <= window_size_wdata;
      end
      if (avg_valid && averages.ready && state != S_OUT) begin
        avg_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            newest_ptr <= newest_ptr + RING_W'(1);
            newest     <= samples.sample;
            win_cur    <= win_eff;
            seen       <= seen_next;
            if (!set_active) begin
              first <= samples.sample;
            end
            set_active <= !samples.last_sample;
            flushing   <= samples.last_sample;
            lag        <= lag_first;
            if (emit) begin
              state     <= S_SUM;
              acc       <= '0;
              pend      <= 1'b0;
              issue_cnt <= win_eff;
              p         <= $signed({1'b0, lag_first + off_eff});
            end
          end
        end
        S_SUM: begin
          if (pend) begin
            acc <= acc_next;
          end
          if (issue_cnt != '0) begin
            pend      <= 1'b1;
            pend_src  <= src;
            p         <= p - P_W'(1);
            issue_cnt <= issue_cnt - WIN_W'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state   <= S_DIV;
              neg     <= acc[SUM_W-1];
              quo     <= mag;
              rem     <= '0;
              div_cnt <= DCNT_W'(NUM_W);
            end
          end
        end
        S_DIV: begin
          rem     <= qbit ? WIN_W'(trial - {1'b0, win_cur}) : WIN_W'(trial);
          quo     <= {quo[NUM_W-2:0], qbit};
          div_cnt <= div_cnt - DCNT_W'(1);
          if (div_cnt == DCNT_W'(1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            avg_valid <= 1'b1;
            avg_data  <= res[AVG_W-1:0];
            avg_last  <= flushing && lag == '0;
            if (flushing && lag != '0) begin
              lag       <= lag_dec;
              state     <= S_SUM;
              acc       <= '0;
              pend      <= 1'b0;
              issue_cnt <= win_cur;
              p         <= $signed({1'b0, lag_dec + off_cur});
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign samples.ready         = state == S_IDLE;
  assign averages.valid        = avg_valid;
  assign averages.average      = avg_data;
  assign averages.last_average = avg_last;

endmodule

// ===== hw/rtl/cma_checker.sv =====
// ----------------------------------------------------------------------------
// cma_checker
// Port-level checks of the centered moving average filter.
// ----------------------------------------------------------------------------
module cma_checker #(
  parameter int AVG_W = 24
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_last,
  input logic             out_valid,
  input logic             out_ready,
  input logic [AVG_W-1:0] out_average,
  input logic             out_last
);

  // hold a stalled average request
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_average) && $stable(out_last))
    else $error("average request changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("average request after reset");

  // end of set always starts a flush
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("sample taken right after end of set");

  // nothing left after the final average of a set
  a_flush_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("average request after final average of set");

endmodule

bind centered_moving_average cma_checker #(
  .AVG_W(SAMPLE_BITS + 8)
) u_cma_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .in_last    (samples.last_sample),
  .out_valid  (averages.valid),
  .out_ready  (averages.ready),
  .out_average(averages.average),
  .out_last   (averages.last_average)
);

// ===== bench/tb_centered_moving_average.sv =====
// ----------------------------------------------------------------------------
// tb_centered_moving_average
// Self-checking bench for the centered moving average filter. Sample sets
// are sent in random bursts while the average receiver stalls on a rolling
// pattern. A scoreboard class keeps its own copy of the sample history and
// the window setting, works out every expected average as each sample
// request is taken, and compares each average request as it arrives. The
// run covers one-sample sets, short sets, sets past the history depth,
// window sizes out of range and a window change in the middle of a set.
// ----------------------------------------------------------------------------
module tb_centered_moving_average
  import cma_pkg::*;
;

  localparam int MAX_WIN      = 64;
  localparam int SAMPLE_W     = 16;
  localparam int AVG_W        = SAMPLE_W + FRAC_BITS;
  localparam int RANDOM_ITEMS = 310;
  localparam int SETTLE       = 160;
  localparam int QUIET_LIMIT  = 5000;

  typedef struct {
    logic signed [AVG_W-1:0] average;
    logic                    last_average;
  } average_t;

  class boxcar_scoreboard;
    logic signed [SAMPLE_W-1:0] history[MAX_WIN];
    int                         seen;
    bit                         active;
    int                         win_cur;
    logic [CFG_W-1:0]           win_reg;
    average_t                   pending_averages[$];
    int                         errors;

    function new();
      foreach (history[i]) history[i] = '0;
      seen    = 0;
      active  = 0;
      win_cur = int'(WINDOW_RESET);
      win_reg = WINDOW_RESET;
      errors  = 0;
    endfunction

    function void write_window(logic [CFG_W-1:0] value);
      win_reg = value;
    endfunction

    function logic signed [SAMPLE_W-1:0] padded(int p, int off);
      if (p < 0) return (-p <= off) ? history[0] : '0;
      if (p >= seen) p = seen - 1;
      if (p < 0) p = 0;
      if (p >= MAX_WIN) p = MAX_WIN - 1;
      return history[p];
    endfunction

    function average_t centered_average(int lag, logic last);
      average_t result;
      longint   sum;
      longint   num;
      longint   q;
      int       off;
      off = (win_cur - 1) / 2;
      sum = 0;
      for (int t = 0; t < win_cur; t++) sum += padded(lag + off - t, off);
      num = sum * 256;
      q = num / win_cur;
      if ((num % win_cur) != 0 && num < 0) q -= 1;
      result.average      = q[AVG_W-1:0];
      result.last_average = last;
      return result;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic last);
      int d;
      int rmax;
      if (!active) begin
        if (win_reg < 1) win_cur = 1;
        else if (win_reg > MAX_WIN) win_cur = MAX_WIN;
        else win_cur = int'(win_reg);
        active = 1;
        seen   = 0;
      end
      for (int i = MAX_WIN - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = s;
      if (seen < MAX_WIN) seen++;
      d = win_cur / 2;
      if (!last) begin
        if (seen >= d + 1)
          pending_averages = {pending_averages, centered_average(d, 1'b0)};
      end else begin
        rmax = seen - 1;
        if (rmax > d) rmax = d;
        for (int r = rmax; r >= 0; r--)
          pending_averages = {pending_averages, centered_average(r, r == 0)};
        active = 0;
        seen   = 0;
      end
    endfunction

    function void check_average(logic signed [AVG_W-1:0] avg, logic last);
      average_t want;
      if (pending_averages.size() == 0) begin
        $error("average: none expected, got %0d (last_average %0b)", avg, last);
        errors++;
        return;
      end
      want = pending_averages.pop_front();
      if (avg !== want.average) begin
        $error("average: expected %0d, got %0d", want.average, avg);
        errors++;
      end
      if (last !== want.last_average) begin
        $error("last_average: expected %0b, got %0b", want.last_average, last);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             window_size_we;
  logic [CFG_W-1:0] window_size_wdata;

  cma_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_if ();
  cma_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_if ();

  centered_moving_average #(
    .MAX_WINDOW (MAX_WIN),
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .window_size_we   (window_size_we),
    .window_size_wdata(window_size_wdata),
    .samples          (in_if),
    .averages         (out_if)
  );

  boxcar_scoreboard sb = new();
  int quiet_cycles = 0;
  int burst_left   = 0;
  int sent         = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_if.valid && out_if.ready)
        sb.check_average(out_if.average, out_if.last_average);
      if (in_if.valid && in_if.ready)
        sb.note_sample(in_if.sample, in_if.last_sample);
      if (window_size_we) sb.write_window(window_size_wdata);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [15:0] stall_mask;
    int          pos;
    stall_mask = '1;
    pos = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (pos == 0) begin
        case ($urandom_range(0, 3))
          0: stall_mask = '1;
          1: stall_mask = 16'($urandom & $urandom);
          default: stall_mask = 16'($urandom | $urandom);
        endcase
      end
      out_if.ready <= stall_mask[pos];
      pos = (pos + 1) % 16;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return SAMPLE_W'(int'($urandom_range(0, 31)) - 16);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_if.valid       <= 1'b1;
    in_if.sample      <= s;
    in_if.last_sample <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_averages.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] value);
    window_size_we    <= 1'b1;
    window_size_wdata <= value;
    @(posedge clk);
    window_size_we    <= 1'b0;
  endtask

  task automatic send_set(input int len);
    for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
  endtask

  initial begin
    int target;
    int win;
    int len;
    int extremes[7];
    extremes = '{0, 1, 2, 63, 64, 65, 127};
    rst               <= 1'b1;
    window_size_we    <= 1'b0;
    window_size_wdata <= '0;
    in_if.valid       <= 1'b0;
    in_if.sample      <= '0;
    in_if.last_sample <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd200, 1'b0);
    drain();
    write_window(7'd3);
    send_sample(16'sd300, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(-16'sd1, 1'b1);
    drain();
    write_window(7'd0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sd5, 1'b1);
    drain();
    write_window(7'd2);
    send_sample(16'sh7FFF, 1'b1);
    drain();
    write_window(7'd127);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd1, 1'b1);
    drain();
    write_window(7'd64);
    send_sample(16'sh8000, 1'b1);

    target = sent + RANDOM_ITEMS;
    while (sent < target) begin
      drain();
      case ($urandom_range(0, 9))
        6: win = $urandom_range(10, 32);
        7: win = $urandom_range(33, 64);
        8: win = $urandom_range(0, 127);
        9: win = extremes[$urandom_range(0, 6)];
        default: win = $urandom_range(1, 9);
      endcase
      write_window(win[CFG_W-1:0]);
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 7) == 0) len = $urandom_range(40, 80);
        else len = $urandom_range(1, 12);
        send_set(len);
      end
    end
    drain();

    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
